@@ rtl/cfb_pkg.sv @@
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// command frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package cfb_pkg;

  localparam logic [7:0]  PREAMBLE_BYTE = 8'hAA;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_TOP       = 16'h8000;

  // frame kinds
  localparam logic OP_POLL   = 1'b0;
  localparam logic OP_SWITCH = 1'b1;

  // configuration register indexes
  localparam logic CFG_POLLING_CODE   = 1'b0;
  localparam logic CFG_SWITCHING_CODE = 1'b1;

  // byte positions inside a frame
  localparam logic [2:0] POS_PRE0 = 3'd0;
  localparam logic [2:0] POS_PRE1 = 3'd1;
  localparam logic [2:0] POS_ID   = 3'd2;
  localparam logic [2:0] POS_CMD  = 3'd3;
  localparam logic [2:0] POS_B4   = 3'd4;
  localparam logic [2:0] POS_B5   = 3'd5;
  localparam logic [2:0] POS_B6   = 3'd6;

  // configuration register file contents
  typedef struct packed {
    logic [7:0] polling_code;
    logic [7:0] switching_code;
  } cfg_t;

  // request as held between the input stage and the serializer
  typedef struct packed {
    logic       is_switch;
    logic [7:0] device_id;
    logic [7:0] cmd;
    logic [7:0] payload;
  } req_t;

  // one byte through the crc, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/cfb_req_if.sv @@
// ----------------------------------------------------------------------------
// cfb_req_if
// Request channel: valid/ready handshake with frame kind, device id and
// switch payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfb_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] device_id;
  logic [7:0] switch_state;

  modport source (output valid, output opcode, output device_id, output switch_state,
                  input ready);
  modport sink   (input valid, input opcode, input device_id, input switch_state,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/cfb_byte_if.sv @@
// ----------------------------------------------------------------------------
// cfb_byte_if
// Frame byte channel: valid/ready handshake with one byte and a last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/cfb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// cfb_cfg_regs
// Command code registers for polling and switch frames.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_cfg_regs import cfb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  output cfg_t            cfg_o
);

  cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POLLING_CODE:   cfg_d.polling_code   = cfg_wdata_i;
        CFG_SWITCHING_CODE: cfg_d.switching_code = cfg_wdata_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.polling_code   <= 8'd0;
      cfg_q.switching_code <= 8'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/cfb_req_stage.sv @@
// ----------------------------------------------------------------------------
// cfb_req_stage
// Input register: holds one request with its command code while the
// serializer sends the previous frame.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_req_stage import cfb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       opcode_i,
  input  wire logic [7:0] device_id_i,
  input  wire logic [7:0] switch_state_i,
  input  wire cfg_t       cfg_i,
  output logic            req_valid_o,
  input  wire logic       req_take_i,
  output req_t            req_o
);

  logic valid_q, valid_d;
  req_t req_q, req_d;
  logic accept;

  // free when empty or when the held request moves on this cycle
  assign in_ready_o = !valid_q || req_take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    req_d   = req_q;
    if (accept) begin
      valid_d           = 1'b1;
      req_d.is_switch   = opcode_i;
      req_d.device_id   = device_id_i;
      req_d.payload     = switch_state_i;
      req_d.cmd         = (opcode_i == OP_SWITCH) ? cfg_i.switching_code
                                                  : cfg_i.polling_code;
    end else if (req_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

`default_nettype wire

@@ rtl/cfb_serializer.sv @@
// ----------------------------------------------------------------------------
// cfb_serializer
// Frame register, byte position counter and running crc; drives one frame
// byte per beat into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_serializer import cfb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_take_o,
  input  wire req_t req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [7:0] out_byte_o,
  output logic      last_byte_o
);

  logic        busy_q, busy_d;
  logic [2:0]  pos_q, pos_d;
  req_t        frm_q, frm_d;
  logic [15:0] crc_q, crc_d;
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        ol_q, ol_d;

  logic        adv;
  logic        step;
  logic        load;
  logic [7:0]  cur_byte;
  logic        cur_last;
  logic        cur_crc;

  // output register can take a byte
  assign adv  = !ov_q || out_ready_i;
  assign step = busy_q && adv;
  assign load = req_valid_i && (!busy_q || (step && cur_last));
  assign req_take_o = load;

  // byte select for the current position
  always_comb begin
    cur_byte = PREAMBLE_BYTE;
    cur_last = 1'b0;
    cur_crc  = 1'b0;
    unique case (pos_q)
      POS_PRE0, POS_PRE1: cur_byte = PREAMBLE_BYTE;
      POS_ID: begin
        cur_byte = frm_q.device_id;
        cur_crc  = 1'b1;
      end
      POS_CMD: begin
        cur_byte = frm_q.cmd;
        cur_crc  = 1'b1;
      end
      POS_B4: begin
        cur_byte = frm_q.is_switch ? frm_q.payload : crc_q[7:0];
        cur_crc  = frm_q.is_switch;
      end
      POS_B5: begin
        cur_byte = crc_q[15:8];
        cur_last = !frm_q.is_switch;
      end
      POS_B6: begin
        cur_byte = crc_q[7:0];
        cur_last = 1'b1;
      end
      default: begin
        cur_byte = PREAMBLE_BYTE;
        cur_last = 1'b1;
      end
    endcase
  end

  // frame sequencing and crc update
  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    frm_d  = frm_q;
    crc_d  = crc_q;
    if (step) begin
      pos_d = pos_q + 3'd1;
      if (cur_crc) begin
        crc_d = crc_feed(crc_q, cur_byte);
      end
      if (cur_last) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      pos_d  = POS_PRE0;
      frm_d  = req_i;
      crc_d  = CRC_INIT;
    end
  end

  // output register
  always_comb begin
    ov_d = ov_q;
    ob_d = ob_q;
    ol_d = ol_q;
    if (step) begin
      ov_d = 1'b1;
      ob_d = cur_byte;
      ol_d = cur_last;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= POS_PRE0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frm_q <= frm_d;
    crc_q <= crc_d;
    ob_q  <= ob_d;
    ol_q  <= ol_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign last_byte_o = ol_q;

  // position never runs past the frame length
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pos_q <= POS_B6))
    else $error("frame position out of range");

  // polling frames end one byte early
  a_poll_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !frm_q.is_switch) |-> (pos_q <= POS_B5))
    else $error("polling frame too long");

  // a new frame starts at the first preamble byte with a fresh crc
  a_load_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (busy_q && pos_q == POS_PRE0 && crc_q == CRC_INIT))
    else $error("frame not initialized on load");

  // a byte only enters the output register while a frame is active
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$past(busy_q) && ov_q && !$past(ov_q)) |-> 1'b0)
    else $error("byte produced while idle");

endmodule

`default_nettype wire

@@ rtl/command_frame_builder_crc16.sv @@
// ----------------------------------------------------------------------------
// command_frame_builder_crc16
// Builds polling and switch command frames with a CRC-16/CCITT-FALSE trailer
// and sends them one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_i   : one request per beat (opcode, device_id, switch_state).
//   frame_o : one frame byte per beat, last_byte set on the final byte.
//             polling frame: AA AA id polling_code crc_lo crc_hi (6 beats)
//             switch frame : AA AA id switching_code state crc_hi crc_lo (7)
//   cfg_*   : write port for polling_code (index 0) and switching_code
//             (index 1); write only while no frame is pending.
// Path: the first byte of a request accepted into an empty block passes
//   the input register, the frame register, then the output register.
// Back-to-back: one request is held in the input register while the
//   previous frame is sent, so frames follow each other with no gap;
//   the frame rate is set by the byte-wide output.
// Reset: no frame pending, polling_code = 0x00, switching_code = 0x01.
// Stall: when frame_o.ready is low the current byte holds, the serializer
//   waits, and req_i.ready drops once the input register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_builder_crc16 import cfb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  cfb_req_if.sink         req_i,
  cfb_byte_if.source      frame_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i
);

  cfg_t cfg;
  req_t req;
  logic req_valid;
  logic req_take;

  // command code registers
  cfb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register
  cfb_req_stage u_req (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_i.valid),
    .in_ready_o     (req_i.ready),
    .opcode_i       (req_i.opcode),
    .device_id_i    (req_i.device_id),
    .switch_state_i (req_i.switch_state),
    .cfg_i          (cfg),
    .req_valid_o    (req_valid),
    .req_take_i     (req_take),
    .req_o          (req)
  );

  // byte serializer with running crc
  cfb_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_take_o  (req_take),
    .req_i       (req),
    .out_valid_o (frame_o.valid),
    .out_ready_i (frame_o.ready),
    .out_byte_o  (frame_o.out_byte),
    .last_byte_o (frame_o.last_byte)
  );

endmodule

`default_nettype wire
